/* hw/rtl/nhbc_pkg.sv */
// Package: shared types, constants and the hash step for the name hash bucket chainer.
package nhbc_pkg;

    localparam int HASH_W   = 32;
    localparam int ENTRY_W  = 16;
    localparam int BKT_O_W  = 10;
    localparam int CFG_W    = 11;
    localparam int UNIT_W   = 16;
    localparam int PARENT_W = 31;

    localparam logic [HASH_W-1:0] HASH_SEED   = 32'd123456789;
    localparam int                ROT_R       = 5;
    localparam int                ROT_L       = 27;
    localparam logic [CFG_W-1:0]  MIN_BUCKETS = 11'd3;

    // Input beat kinds
    typedef enum logic [1:0] {
        ACT_UNIT  = 2'd0,
        ACT_EMPTY = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    // One bucket head slot
    typedef struct packed {
        logic               valid;
        logic [ENTRY_W-1:0] entry;
    } t_head;

    // Divider handshake between sequencer and shared modulo unit
    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

    // Rotate right by five, then fold in one code unit
    function automatic logic [HASH_W-1:0] f_hash_step(input logic [HASH_W-1:0] h,
                                                      input logic [UNIT_W-1:0] u);
        return ((h >> ROT_R) | (h << ROT_L)) ^ {{(HASH_W-UNIT_W){1'b0}}, u};
    endfunction

endpackage

/* hw/rtl/nhbc_mod_unit.sv */
// Shared modulo unit: restoring division, one quotient bit per cycle, remainder only.
module nhbc_mod_unit
    import nhbc_pkg::*;
#(
    parameter int DIV_W = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_ctl          i_ctl,       // start used
    input  logic [HASH_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,   // held stable while busy
    output t_div_ctl          o_ctl,       // done used
    output logic [DIV_W-1:0]  o_rem
);

    localparam int CNT_W = $clog2(HASH_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [HASH_W-1:0] r_num;
    logic [DIV_W-1:0]  r_rem;

    logic [DIV_W:0]    w_trial;
    logic [DIV_W:0]    w_diff;
    logic [DIV_W-1:0]  n_rem;

    // One restoring step: shift in next bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_num[HASH_W-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        if (w_trial >= {1'b0, i_divisor}) begin
            n_rem = w_diff[DIV_W-1:0];
        end else begin
            n_rem = w_trial[DIV_W-1:0];
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_num <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= n_rem;
        end
    end

    always_comb begin
        o_ctl       = '0;
        o_ctl.done  = r_done;
        o_rem       = r_rem;
    end

endmodule

/* hw/rtl/nhbc_head_mem.sv */
// Bucket head memory: one write port, one registered read port.
module nhbc_head_mem
    import nhbc_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_head         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_head         o_rdata
);

    t_head r_mem [DEPTH];
    t_head r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/name_hash_bucket_chainer.sv */
// Top level: name hash bucket chainer with sequencer, shared modulo unit and head memory.
//
//  Channel     | Dir | Beat contents
//  ------------+-----+---------------------------------------------------------------
//  s_axis      | in  | tdata: name_unit, parent_offset; tuser: action, first_unit;
//              |     | tlast: last_unit
//  m_axis      | out | tdata: entry_number, bucket_index, hash_value, prev_valid,
//              |     | prev_entry
//  cfg         | in  | bucket_count, written when i_cfg_we is high
//
// A name unit that is not the last is taken and hashed while the sequencer is idle. A last
// unit or an empty-name entry is hashed, then runs through the bit-serial modulo unit,
// hands the remainder back, reads the head memory and finally writes the new head and
// loads the output register.
// A clear beat and reset each start a sweep over all MAX_BUCKETS head slots, during which
// no beat is taken. A stalled output only holds the entry in its final step, ST_DONE;
// earlier work and non-final units still proceed.
module name_hash_bucket_chainer
    import nhbc_pkg::*;
#(
    parameter int MAX_BUCKETS = 1024,
    parameter int MAX_ENTRIES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [15:0] name_unit, [46:16] parent_offset, [47] 0
    input  logic [2:0]  i_s_axis_tuser,   // [1:0] action, [2] first_unit
    input  logic        i_s_axis_tlast,   // last_unit
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // [15:0] entry_number, [25:16] bucket_index,
                                          // [57:26] hash_value, [58] prev_valid,
                                          // [74:59] prev_entry, [79:75] 0
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata       // bucket_count
);

    localparam int BW     = (MAX_BUCKETS > 2) ? $clog2(MAX_BUCKETS) : 1;
    localparam int DW     = $clog2(MAX_BUCKETS + 1);
    localparam int BWX    = (BW > BKT_O_W) ? BW : BKT_O_W;
    localparam int ENT_LIM = (MAX_ENTRIES < 65536) ? MAX_ENTRIES : 65536;
    localparam logic [ENTRY_W-1:0] ENTRY_LAST  = ENTRY_W'(ENT_LIM - 1);
    localparam logic [BW-1:0]      BUCKET_LAST = BW'(MAX_BUCKETS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_DONE
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_cfg;
    logic [HASH_W-1:0]  r_hash;
    logic [ENTRY_W-1:0] r_next;
    logic [BW-1:0]      r_clr_addr;
    logic [BW-1:0]      r_bucket;
    logic [DW-1:0]      r_div;
    logic               r_out_valid;
    logic [79:0]        r_out_data;

    logic               w_in_accept;
    t_action            w_action;
    logic [UNIT_W-1:0]  w_unit;
    logic [PARENT_W-1:0] w_parent;
    logic [HASH_W-1:0]  w_seed_hash;
    logic [HASH_W-1:0]  w_unit_hash;
    logic [HASH_W-1:0]  w_new_hash;
    logic               w_finish;
    logic [31:0]        w_cfg_ext;
    logic [DW-1:0]      n_div;
    t_div_ctl           w_div_in;
    t_div_ctl           w_div_out;
    logic [DW-1:0]      w_rem;
    logic               w_fire;
    logic               w_mem_we;
    logic [BW-1:0]      w_mem_waddr;
    t_head              w_mem_wdata;
    t_head              w_head;
    logic [BWX-1:0]     w_bucket_ext;
    logic [ENTRY_W-1:0] w_prev_entry;
    logic [79:0]        n_out_data;

    // Input beat decode and hash step
    always_comb begin
        w_in_accept = i_s_axis_tvalid & o_s_axis_tready;
        w_action    = t_action'(i_s_axis_tuser[1:0]);
        w_unit      = i_s_axis_tdata[15:0];
        w_parent    = i_s_axis_tdata[46:16];
        w_seed_hash = {1'b0, w_parent} ^ HASH_SEED;
        w_unit_hash = f_hash_step(i_s_axis_tuser[2] ? w_seed_hash : r_hash, w_unit);
        w_finish    = 1'b0;
        w_new_hash  = w_unit_hash;
        case (w_action)
            ACT_UNIT: begin
                w_finish   = i_s_axis_tlast;
                w_new_hash = w_unit_hash;
            end
            ACT_EMPTY: begin
                w_finish   = 1'b1;
                w_new_hash = w_seed_hash;
            end
            default: begin
                w_finish   = 1'b0;
                w_new_hash = w_unit_hash;
            end
        endcase
    end

    // Divisor: bucket count saturated into 3 .. MAX_BUCKETS
    always_comb begin
        w_cfg_ext = 32'(r_cfg);
        if (r_cfg < MIN_BUCKETS) begin
            n_div = DW'(MIN_BUCKETS);
        end else if (w_cfg_ext > 32'(MAX_BUCKETS)) begin
            n_div = DW'(MAX_BUCKETS);
        end else begin
            n_div = DW'(r_cfg);
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        w_div_in       = '0;
        w_div_in.start = w_in_accept & w_finish;
    end

    nhbc_mod_unit #(
        .DIV_W (DW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_in),
        .i_dividend (w_new_hash),
        .i_divisor  (r_div),
        .o_ctl      (w_div_out),
        .o_rem      (w_rem)
    );

    // Head memory write: sweep while clearing, new head when the entry loads the output register
    always_comb begin
        w_fire      = (r_state == ST_DONE) & (~r_out_valid | i_m_axis_tready);
        w_mem_we    = (r_state == ST_CLEAR) | w_fire;
        w_mem_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_bucket;
        w_mem_wdata.valid = (r_state != ST_CLEAR);
        w_mem_wdata.entry = (r_state == ST_CLEAR) ? '0 : r_next;
    end

    nhbc_head_mem #(
        .DEPTH (MAX_BUCKETS),
        .AW    (BW)
    ) u_heads (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (r_bucket),
        .o_rdata (w_head)
    );

    // Result beat assembly
    always_comb begin
        w_bucket_ext = BWX'(r_bucket);
        w_prev_entry = w_head.valid ? w_head.entry : '0;
        n_out_data   = {5'b0, w_prev_entry, w_head.valid, r_hash,
                        w_bucket_ext[BKT_O_W-1:0], r_next};
    end

    // Sequencer, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cfg       <= MIN_BUCKETS;
            r_hash      <= '0;
            r_next      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            // new entry loads the output register, a taken beat empties it
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid & i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == BUCKET_LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_in_accept) begin
                        if (w_action == ACT_CLEAR) begin
                            r_hash     <= '0;
                            r_next     <= '0;
                            r_clr_addr <= '0;
                            r_state    <= ST_CLEAR;
                        end else if (w_action == ACT_UNIT || w_action == ACT_EMPTY) begin
                            r_hash <= w_new_hash;
                            if (w_finish) begin
                                r_state <= ST_DIV;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_out.done) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_fire) begin
                        r_next  <= (r_next == ENTRY_LAST) ? '0 : r_next + 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_div_in.start) begin
            r_div <= n_div;
        end
        if (w_div_out.done) begin
            r_bucket <= BW'(w_rem);
        end
        if (w_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Checks
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_out.done |-> (r_state == ST_DIV))
        else $error("modulo unit finished outside the divide phase");

    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (DW'(r_bucket) < r_div))
        else $error("bucket index not below divisor");

    a_fire_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("finished entry did not reach the output register");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && w_action == ACT_CLEAR) |=> !o_s_axis_tready)
        else $error("input taken during clear sweep");

endmodule
